// ----- rtl/core/palette_builder_and_mapper_macros.svh -----
// ----------------------------------------------------------------------------
// palette builder and mapper assertion macros
// concurrent assertion shorthands on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef PALETTE_BUILDER_AND_MAPPER_MACROS_SVH
`define PALETTE_BUILDER_AND_MAPPER_MACROS_SVH

// same-cycle implication
`define PBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pbm_pkg.sv -----
// ----------------------------------------------------------------------------
// pbm_pkg
// shared types, constants and helpers of the palette builder and mapper
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned IdxW         = 8;
  localparam int unsigned CntW         = 9;
  localparam int unsigned WordW        = 32;

  typedef enum logic [1:0] {
    FUNC_LEARN  = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MODE_GRAY = 2'd0,
    MODE_RGB  = 2'd1,
    MODE_RGBA = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] func;
    logic       first_of_image;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] entry_index;
  } pbm_in_t;

  typedef struct packed {
    logic [7:0]      color_index;
    logic            found;
    logic            added;
    logic            overflow;
    logic [CntW-1:0] num_colors;
    logic [1:0]      size_class;
    logic [7:0]      entry_red;
    logic [7:0]      entry_green;
    logic [7:0]      entry_blue;
    logic [7:0]      entry_alpha;
  } pbm_out_t;

  // search token that walks the cell chain
  typedef struct packed {
    logic             vld;
    logic             done;
    logic             hit;
    logic             added;
    logic [1:0]       func;
    logic [1:0]       mode;
    logic [WordW-1:0] word;
    logic [CntW-1:0]  cnt;
    logic [IdxW-1:0]  ei;
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] entry;
  } pbm_tok_t;

  function automatic logic [WordW-1:0] mode_mask(input logic [1:0] mode);
    logic [WordW-1:0] m;
    case (mode)
      MODE_GRAY: m = 32'h0000_00FF;
      MODE_RGB:  m = 32'h00FF_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] size_class_of(input logic [CntW-1:0] n);
    logic [1:0] c;
    if (n <= CntW'(2))       c = 2'd0;
    else if (n <= CntW'(4))  c = 2'd1;
    else if (n <= CntW'(16)) c = 2'd2;
    else                     c = 2'd3;
    return c;
  endfunction

endpackage

// ----- rtl/core/pbm_if.sv -----
// ----------------------------------------------------------------------------
// pbm_if
// valid/ready channels of the palette builder and mapper
// ----------------------------------------------------------------------------
interface pbm_in_if import pbm_pkg::*; ();
  logic    valid;
  logic    ready;
  pbm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pbm_out_if import pbm_pkg::*; ();
  logic     valid;
  logic     ready;
  pbm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/palette_builder_and_mapper.sv -----
// ----------------------------------------------------------------------------
// palette_builder_and_mapper
// learns up to PALETTE_DEPTH distinct colors, maps pixels to indices, reads entries
// ----------------------------------------------------------------------------
// chain walk: the token passes the cell chain one cell per cycle, then the
//   result is registered at the output; one token in flight, so no new item
//   is taken until the last one has left the chain and the skid slot is empty
// reset: count and overflow cleared, mode rgb, palette entries left as they are
// ----------------------------------------------------------------------------
module palette_builder_and_mapper import pbm_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PaletteDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbm_in_if.sink     in_i,
  pbm_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i
);

  // tok[k] enters cell k, tok[PALETTE_DEPTH] returns to the controller
  pbm_tok_t tok [PALETTE_DEPTH+1];

  // controller: mode register, entry count, sticky overflow, result staging.
  // a learn beat with first_of_image clears count and overflow at launch,
  // so the token already carries the emptied count down the chain
  pbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .tok_o      (tok[0]),
    .tok_i      (tok[PALETTE_DEPTH])
  );

  // chain of entry cells; cell k holds palette entry k.
  // the first cell below the count that matches claims the token, so the
  // lowest index wins; on a learn miss the cell at the count appends.
  // a learn token that leaves the chain unclaimed means the store is full
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    pbm_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

endmodule

// ----- rtl/core/pbm_cell.sv -----
// ----------------------------------------------------------------------------
// pbm_cell
// one palette entry: compares, appends or reads as the token passes by
// ----------------------------------------------------------------------------
module pbm_cell import pbm_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pbm_tok_t tok_i,
  output pbm_tok_t tok_o
);

  localparam logic [CntW-1:0] MyCnt = CntW'(Idx);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic [WordW-1:0] ent_q;
  pbm_tok_t         tok_d, tok_q;
  logic             in_range, match, wr_en;

  assign in_range = MyCnt < tok_i.cnt;
  assign match    = ((ent_q ^ tok_i.word) & mode_mask(tok_i.mode)) == '0;

  always_comb begin
    tok_d = tok_i;
    wr_en = 1'b0;
    if (tok_i.vld && !tok_i.done) begin
      case (tok_i.func)
        FUNC_LEARN: begin
          if (in_range && match) begin
            tok_d.done = 1'b1;
            tok_d.hit  = 1'b1;
            tok_d.idx  = MyIdx;
          end else if (MyCnt == tok_i.cnt) begin
            // first free slot: append here
            wr_en       = 1'b1;
            tok_d.done  = 1'b1;
            tok_d.added = 1'b1;
            tok_d.idx   = MyIdx;
          end
        end
        FUNC_LOOKUP: begin
          if (in_range && match) begin
            tok_d.done = 1'b1;
            tok_d.hit  = 1'b1;
            tok_d.idx  = MyIdx;
          end
        end
        FUNC_READ: begin
          if (in_range && (tok_i.ei == MyIdx)) begin
            tok_d.done  = 1'b1;
            tok_d.hit   = 1'b1;
            tok_d.idx   = MyIdx;
            tok_d.entry = ent_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_q <= tok_i.word;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/core/pbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbm_ctrl
// launches tokens, keeps count, overflow and mode, stages results
// ----------------------------------------------------------------------------
module pbm_ctrl import pbm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pbm_in_if.sink        in_i,
  pbm_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_data_i,
  output pbm_tok_t      tok_o,
  input  pbm_tok_t      tok_i
);

  logic            busy_q;
  logic [1:0]      mode_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_set;
  logic            out_vld_q, skid_vld_q;
  pbm_out_t        out_q, skid_q, res;
  logic            accept, clr, out_fire;
  pbm_in_t         px;

  assign px       = in_i.data;
  assign in_i.ready = !busy_q && !skid_vld_q;
  assign accept   = in_i.valid && in_i.ready;
  assign clr      = (px.func == FUNC_LEARN) && px.first_of_image;
  assign out_fire = out_vld_q && out_o.ready;

  always_comb begin
    tok_o       = '0;
    tok_o.vld   = accept;
    tok_o.func  = px.func;
    tok_o.mode  = mode_q;
    tok_o.ei    = px.entry_index;
    tok_o.cnt   = clr ? '0 : cnt_q;
    case (mode_q)
      MODE_GRAY: tok_o.word = {8'hFF, px.red, px.red, px.red};
      MODE_RGB:  tok_o.word = {8'hFF, px.blue, px.green, px.red};
      default:   tok_o.word = {px.alpha, px.blue, px.green, px.red};
    endcase
  end

  // result of the token leaving the chain
  assign ovf_set = (tok_i.func == FUNC_LEARN) && !tok_i.done;
  assign cnt_d   = tok_i.cnt + CntW'(tok_i.added);

  always_comb begin
    res             = '0;
    res.color_index = tok_i.idx;
    res.found       = tok_i.hit;
    res.added       = tok_i.added;
    res.overflow    = ovf_q | ovf_set;
    res.num_colors  = cnt_d;
    res.size_class  = size_class_of(cnt_d);
    res.entry_red   = tok_i.entry[7:0];
    res.entry_green = tok_i.entry[15:8];
    res.entry_blue  = tok_i.entry[23:16];
    res.entry_alpha = tok_i.entry[31:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      mode_q     <= MODE_RGB;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
        if (clr) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end
      end
      if (tok_i.vld) begin
        busy_q <= 1'b0;
        cnt_q  <= cnt_d;
        ovf_q  <= ovf_q | ovf_set;
      end
      // output register with one skid slot behind it
      if (tok_i.vld) begin
        if (!out_vld_q || out_fire) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_vld_q  <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      if (!out_vld_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_fire && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

// ----- rtl/core/pbm_checker.sv -----
// ----------------------------------------------------------------------------
// pbm_checker
// port-level checks of the palette builder and mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "palette_builder_and_mapper_macros.svh"

module pbm_checker import pbm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input pbm_out_t out_data_i
);

  // stalled result beat holds
  `PBM_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, $stable(out_data_i), "out beat changed while stalled")

  // one item at a time: no accept right after an accept
  `PBM_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i, "input taken while busy")

  // appended entry lands at the old count
  `PBM_ASSERT_IMP(a_add_idx, out_valid_i && out_data_i.added, out_data_i.num_colors == 9'(out_data_i.color_index) + 9'd1, "added index not at count")

  `PBM_ASSERT_IMP(a_found_added, out_valid_i, !(out_data_i.found && out_data_i.added), "found and added together")

endmodule

bind palette_builder_and_mapper pbm_checker u_pbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ----- tb/palette_builder_and_mapper_test.sv -----
// ----------------------------------------------------------------------------
// palette_builder_and_mapper_test
// streams learn, look-up and read beats through the palette block under
// random gaps and back-pressure; a shadow palette predicts each result beat,
// which is checked field by field in order of arrival
// ----------------------------------------------------------------------------
module palette_builder_and_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pbm_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned PIXELS_RANDOM  = 1750;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // codes the package leaves without a name
  localparam logic [1:0]  FUNC_SPARE     = 2'd3;
  localparam logic [1:0]  MODE_SPARE     = 2'd3;

  typedef enum logic [1:0] {STIM_PIXEL, STIM_MODE, STIM_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e kind;
    pbm_in_t    px;
    logic [1:0] mode;
  } stim_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we;
  logic [1:0] cfg_data;

  pbm_in_if  pix_if ();
  pbm_out_if res_if ();

  palette_builder_and_mapper DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pix_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow copy of the palette state
  logic [WordW-1:0] shadow_store [PaletteDepth];
  logic [CntW-1:0]  shadow_count    = '0;
  logic             shadow_overflow = 1'b0;
  logic [1:0]       shadow_mode     = MODE_RGB;

  pbm_out_t    awaited_results [$];
  stim_t       stim_q [$];
  logic [1:0]  plan_mode      = MODE_RGB;  // mode in force where the next beat lands
  int unsigned planned_pixels = 0;
  int unsigned pixels_offered = 0;
  int unsigned pixels_taken   = 0;
  int unsigned fault_count    = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned idle_in        = 0;
  int unsigned quiet_in       = 0;
  int unsigned stall_out      = 0;
  int unsigned quiet_out      = 0;

  // expected result of one pixel beat, advancing the shadow state
  function automatic pbm_out_t map_pixel(input pbm_in_t px);
    pbm_out_t         res;
    logic [WordW-1:0] word;
    logic [WordW-1:0] mask;
    logic [IdxW-1:0]  hit_idx;
    logic             hit;
    res     = '0;
    hit     = 1'b0;
    hit_idx = '0;
    // packed form the current mode stores, and the bytes it compares
    case (shadow_mode)
      MODE_GRAY: begin
        word = {8'hFF, px.red, px.red, px.red};
        mask = 32'h0000_00FF;
      end
      MODE_RGB: begin
        word = {8'hFF, px.blue, px.green, px.red};
        mask = 32'h00FF_FFFF;
      end
      default: begin
        word = {px.alpha, px.blue, px.green, px.red};
        mask = 32'hFFFF_FFFF;
      end
    endcase
    // start of a new image empties the palette before the learn
    if (px.func == FUNC_LEARN && px.first_of_image) begin
      shadow_count    = '0;
      shadow_overflow = 1'b0;
    end
    // lowest stored entry that matches wins
    for (int i = 0; i < PaletteDepth; i++) begin
      if (!hit && i < shadow_count && ((shadow_store[i] ^ word) & mask) == '0) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
    case (px.func)
      FUNC_LEARN: begin
        if (hit) begin
          res.color_index = hit_idx;
          res.found       = 1'b1;
        end else if (shadow_count < PaletteDepth) begin
          shadow_store[shadow_count[IdxW-1:0]] = word;
          res.color_index = shadow_count[IdxW-1:0];
          res.added       = 1'b1;
          shadow_count++;
        end else begin
          // palette full: nothing stored, flag sticks until the next image
          shadow_overflow = 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        if (hit) begin
          res.color_index = hit_idx;
          res.found       = 1'b1;
        end
      end
      FUNC_READ: begin
        // entries at or past the count read back as zeros
        if (px.entry_index < shadow_count) begin
          res.color_index = px.entry_index;
          res.found       = 1'b1;
          {res.entry_alpha, res.entry_blue, res.entry_green, res.entry_red} =
            shadow_store[px.entry_index];
        end
      end
      default: ;  // spare func leaves the state alone
    endcase
    res.overflow    = shadow_overflow;
    res.num_colors  = shadow_count;
    res.size_class  = (shadow_count > 16) ? 2'd3 :
                      (shadow_count > 4)  ? 2'd2 :
                      (shadow_count > 2)  ? 2'd1 : 2'd0;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, name, want_v, got_v);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  // random junk in the bytes the current mode does not compare
  function automatic logic [31:0] scramble_unused(input logic [31:0] color);
    logic [31:0] noise = $urandom();
    case (plan_mode)
      MODE_GRAY: return {noise[31:8], color[7:0]};
      MODE_RGB:  return {noise[31:24], color[23:0]};
      default:   return color;
    endcase
  endfunction

  // color is packed {alpha, blue, green, red}
  task automatic plan_pixel(input logic [1:0] fn, input logic first,
                            input logic [31:0] color, input logic [7:0] ei);
    stim_t s;
    s.kind              = STIM_PIXEL;
    s.mode              = plan_mode;
    s.px.func           = fn;
    s.px.first_of_image = first;
    {s.px.alpha, s.px.blue, s.px.green, s.px.red} = color;
    s.px.entry_index    = ei;
    stim_q.push_back(s);
    planned_pixels++;
  endtask

  task automatic plan_mode_write(input logic [1:0] m);
    stim_t s;
    s.kind    = STIM_MODE;
    s.mode    = m;
    s.px      = '0;
    plan_mode = m;
    stim_q.push_back(s);
  endtask

  task automatic plan_drain();
    stim_t s;
    s.kind = STIM_DRAIN;
    s.mode = plan_mode;
    s.px   = '0;
    stim_q.push_back(s);
  endtask

  // one image: a small set of colors, learned, looked up and read back,
  // with some noise and restarts mixed in
  task automatic plan_image(input int unsigned n_colors, input int unsigned n_items);
    logic [31:0] pool [$];
    logic [31:0] pick;
    int unsigned roll;
    pool.push_back($urandom());
    while (pool.size() < n_colors) begin
      pick = $urandom();
      // same rgb as an earlier color, other alpha: only rgba tells them apart
      if ($urandom_range(0, 3) == 0) pick[23:0] = pool[$urandom_range(0, pool.size() - 1)][23:0];
      pool.push_back(pick);
    end
    plan_pixel(FUNC_LEARN, 1'b1, scramble_unused(pool[0]), 8'($urandom()));
    for (int k = 1; k < n_items; k++) begin
      // sometimes the mode flips in the middle of an image
      if (k == n_items / 2 && $urandom_range(0, 5) == 0) plan_mode_write(2'($urandom_range(0, 3)));
      roll = $urandom_range(0, 99);
      pick = scramble_unused(pool[$urandom_range(0, pool.size() - 1)]);
      if (roll < 55)
        plan_pixel(FUNC_LEARN, $urandom_range(0, 39) == 0, pick, 8'($urandom()));
      else if (roll < 75)
        plan_pixel(FUNC_LOOKUP, 1'($urandom()), (roll < 71) ? pick : $urandom(),
                   8'($urandom()));
      else if (roll < 92)
        plan_pixel(FUNC_READ, 1'($urandom()), $urandom(),
                   (roll < 87) ? 8'($urandom_range(0, n_colors + 2)) : 8'($urandom()));
      else if (roll < 96)
        plan_pixel(FUNC_SPARE, 1'($urandom()), $urandom(), 8'($urandom()));
      else
        plan_pixel(FUNC_LEARN, 1'($urandom()), $urandom(), 8'($urandom()));
    end
  endtask

  // fill the whole palette with fresh colors and run past it into overflow
  task automatic plan_fill(input int unsigned extra);
    logic [31:0] seen [$];
    logic [31:0] pick;
    plan_pixel(FUNC_LEARN, 1'b1, $urandom(), 8'($urandom()));
    for (int k = 0; k < PaletteDepth + extra; k++) begin
      pick = $urandom();
      plan_pixel(FUNC_LEARN, 1'b0, pick, 8'($urandom()));
      seen.push_back(pick);
      if (k % 8 == 7)
        plan_pixel(FUNC_LOOKUP, 1'($urandom()), seen[$urandom_range(0, seen.size() - 1)],
                   8'($urandom()));
    end
    // stored colors still match once the palette is full
    for (int k = 0; k < 8; k++)
      plan_pixel(FUNC_LEARN, 1'b0, seen[$urandom_range(0, seen.size() - 1)], 8'($urandom()));
    for (int k = 0; k < 24; k++)
      plan_pixel(FUNC_READ, 1'($urandom()), $urandom(), 8'($urandom()));
    for (int k = 0; k < 12; k++)
      plan_pixel(FUNC_LOOKUP, 1'b0, (k % 2 == 0) ? seen[$urandom_range(0, seen.size() - 1)]
                                                 : $urandom(), 8'($urandom()));
  endtask

  // pixel driver: presents beats at the falling edge, a beat leaves once taken
  always @(negedge clk_i) begin : pixel_driver
    logic    drv_valid;
    pbm_in_t drv_data;
    logic    drv_we;
    drv_valid = pix_if.valid;
    drv_data  = pix_if.data;
    drv_we    = 1'b0;
    if (rst_ni) begin
      // now and then a long stretch with no gaps at all
      if (quiet_in > 0) quiet_in--;
      else if ($urandom_range(0, 1999) == 0) quiet_in = $urandom_range(2000, 6000);
      if (pix_if.valid && pixels_taken == pixels_offered) drv_valid = 1'b0;
      if (!drv_valid) begin
        if (idle_in > 0) begin
          idle_in--;
        end else if (stim_q.size() != 0) begin
          case (stim_q[0].kind)
            STIM_PIXEL: begin
              drv_valid = 1'b1;
              drv_data  = stim_q[0].px;
              void'(stim_q.pop_front());
              pixels_offered++;
              idle_in = (quiet_in > 0) ? 0 : pick_idle();
            end
            STIM_MODE: begin
              // mode only changes with no pixel in flight
              if (awaited_results.size() == 0) begin
                drv_we   = 1'b1;
                cfg_data <= stim_q[0].mode;
                void'(stim_q.pop_front());
              end
            end
            default: begin
              // hold off the sender until every result is back
              if (awaited_results.size() == 0) void'(stim_q.pop_front());
            end
          endcase
        end
      end
    end
    pix_if.valid <= drv_valid;
    pix_if.data  <= drv_data;
    cfg_we       <= drv_we;
  end

  // result sink: random back-pressure
  always @(negedge clk_i) begin : result_sink
    logic drv_ready;
    drv_ready = 1'b1;
    if (quiet_out > 0) quiet_out--;
    else if ($urandom_range(0, 1999) == 0) quiet_out = $urandom_range(2000, 6000);
    if (stall_out > 0) begin
      stall_out--;
      drv_ready = 1'b0;
    end else if (quiet_out == 0 && $urandom_range(0, 99) < 15) begin
      stall_out = pick_idle();
      drv_ready = 1'b0;
    end
    res_if.ready <= rst_ni ? drv_ready : 1'b0;
  end

  // monitor: predicts on each taken pixel beat, checks each result beat
  always @(posedge clk_i) begin : result_monitor
    pbm_out_t want;
    logic     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we) shadow_mode = cfg_data;
      if (pix_if.valid && pix_if.ready) begin
        awaited_results.push_back(map_pixel(pix_if.data));
        pixels_taken++;
        moved = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("%0t result beat with no pixel pending", $realtime);
        end else begin
          want = awaited_results.pop_front();
          check_field("color_index", want.color_index, res_if.data.color_index);
          check_field("found",       want.found,       res_if.data.found);
          check_field("added",       want.added,       res_if.data.added);
          check_field("overflow",    want.overflow,    res_if.data.overflow);
          check_field("num_colors",  want.num_colors,  res_if.data.num_colors);
          check_field("size_class",  want.size_class,  res_if.data.size_class);
          check_field("entry_red",   want.entry_red,   res_if.data.entry_red);
          check_field("entry_green", want.entry_green, res_if.data.entry_green);
          check_field("entry_blue",  want.entry_blue,  res_if.data.entry_blue);
          check_field("entry_alpha", want.entry_alpha, res_if.data.entry_alpha);
        end
      end
      // watchdog on beats in either direction
      if (moved) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pixel_goal;
    int unsigned img;
    int unsigned roll;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    res_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = MODE_RGB;

    // directed: empty palette, rgb mode out of reset
    plan_pixel(FUNC_READ,   1'b0, 32'h0000_0000, 8'h00);  // read with nothing stored
    plan_pixel(FUNC_LOOKUP, 1'b0, 32'h0000_0000, 8'h00);  // miss on empty palette
    plan_pixel(FUNC_LEARN,  1'b1, 32'h0000_0000, 8'h00);  // new image, entry 0
    plan_pixel(FUNC_LEARN,  1'b0, 32'hFFFF_FFFF, 8'hFF);  // entry 1
    plan_pixel(FUNC_LEARN,  1'b0, 32'hFF00_0000, 8'h00);  // alpha ignored, hits 0
    plan_pixel(FUNC_LOOKUP, 1'b0, 32'h00FF_FFFF, 8'h00);  // hits 1
    plan_pixel(FUNC_LOOKUP, 1'b1, 32'h0056_3412, 8'h00);  // miss, first flag ignored
    plan_pixel(FUNC_READ,   1'b1, 32'h0000_0000, 8'h01);  // alpha stored as ff
    plan_pixel(FUNC_READ,   1'b0, 32'h0000_0000, 8'hFF);  // far out of range
    plan_pixel(FUNC_SPARE,  1'b1, 32'hFFFF_FFFF, 8'hFF);  // spare func changes nothing
    plan_pixel(FUNC_READ,   1'b0, 32'h0000_0000, 8'h02);  // just past the count
    plan_drain();
    // gray: one byte compared, stored as r=g=b
    plan_mode_write(MODE_GRAY);
    plan_pixel(FUNC_LEARN,  1'b1, 32'h0302_0180, 8'h00);
    plan_pixel(FUNC_LEARN,  1'b0, 32'hAAFF_7F80, 8'h00);  // same red, hits 0
    plan_pixel(FUNC_LEARN,  1'b0, 32'h0000_0001, 8'h00);
    plan_pixel(FUNC_READ,   1'b0, 32'h0000_0000, 8'h00);
    // rgba mid-image: gray entries keep their stored form
    plan_mode_write(MODE_RGBA);
    plan_pixel(FUNC_LOOKUP, 1'b0, 32'hFF80_8080, 8'h00);
    plan_pixel(FUNC_LOOKUP, 1'b0, 32'hFE80_8080, 8'h00);  // alpha differs, miss
    plan_pixel(FUNC_LEARN,  1'b0, 32'hFE80_8080, 8'h00);
    // spare mode compares like rgba
    plan_mode_write(MODE_SPARE);
    plan_pixel(FUNC_LEARN,  1'b0, 32'hFE80_8080, 8'h00);
    plan_pixel(FUNC_LEARN,  1'b0, 32'h0403_0201, 8'h00);
    plan_pixel(FUNC_LEARN,  1'b0, 32'h0000_0000, 8'h00);  // count crosses four
    plan_pixel(FUNC_READ,   1'b0, 32'h0000_0000, 8'h04);

    // random images, two of them filling the palette past its end
    pixel_goal = planned_pixels + PIXELS_RANDOM;
    img        = 0;
    while (planned_pixels < pixel_goal) begin
      if (img == 1) begin
        plan_mode_write(MODE_RGB);
        plan_fill(20);
      end else if (img == 12) begin
        plan_mode_write(MODE_RGBA);
        plan_fill(12);
      end else begin
        plan_mode_write(2'($urandom_range(0, 3)));
        roll = $urandom_range(0, 99);
        plan_image((roll < 65) ? $urandom_range(1, 5) :
                   (roll < 90) ? $urandom_range(6, 20) : $urandom_range(21, 60),
                   $urandom_range(15, 70));
      end
      if ($urandom_range(0, 9) == 0) plan_drain();
      img++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || awaited_results.size() != 0 || pix_if.valid)
      @(posedge clk_i);
    // room for any stray result beat
    repeat (PaletteDepth + 32) @(posedge clk_i);
    if (fault_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
